// ----- rtl/core/mfud_pkg.sv -----
// ----------------------------------------------------------------------------
// mfud_pkg: shared constants for the market feed unit deframer
// Field widths, register indexes, event codes and header byte positions.
// ----------------------------------------------------------------------------
package mfud_pkg;

    localparam int MAX_FRAME_BYTES = 65536;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int OFF_W           = 10;
    localparam int CMP_W           = (POS_W > OFF_W) ? POS_W : OFF_W;
    localparam int CFG_DATA_W      = 10;
    localparam int SEQ_W           = 32;
    localparam int MSEQ_W          = 33;

    localparam logic [OFF_W-1:0] OFFSET_RESET  = 10'd42;
    localparam logic [7:0]       UNIT_RESET    = 8'd1;

    localparam logic CFG_HEADER_OFFSET = 1'b0;
    localparam logic CFG_UNIT_ID       = 1'b1;

    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_GAP     = 2'd1;
    localparam logic [1:0] EV_BAD_LEN = 2'd2;

    localparam logic [2:0] HDR_COUNT_POS = 3'd2;
    localparam logic [2:0] HDR_UNIT_POS  = 3'd3;
    localparam logic [2:0] HDR_SEQ0_POS  = 3'd4;
    localparam logic [2:0] HDR_SEQ1_POS  = 3'd5;
    localparam logic [2:0] HDR_SEQ2_POS  = 3'd6;
    localparam logic [2:0] HDR_SEQ3_POS  = 3'd7;
    localparam int         HDR_BYTES     = 8;

    localparam logic [7:0] MIN_MSG_LEN   = 8'd2;
    localparam logic [8:0] LEN_OVERHEAD  = 9'd3;

endpackage

// ----- rtl/core/market_feed_unit_deframer_top.sv -----
// ----------------------------------------------------------------------------
// market_feed_unit_deframer_top: sequenced-unit header deframer
// Skips the link header, checks the unit header and splits the frame body
// into messages, tagging each payload byte with type and sequence numbers.
//
//   channel   direction  ports
//   s_        in         s_valid s_ready s_frame_byte s_frame_end
//   m_        out        m_valid m_ready m_event_res .. m_expected_seq
//   cfg_      in         cfg_wr_en cfg_wr_index cfg_wr_data
//
// one byte per cycle while results are taken: an input register feeds one pass
// of frame logic into the result register
// bytes with no result never wait for the result register
// a stalled result still lets one more byte into the input register
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module market_feed_unit_deframer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_index,
    input  logic [mfud_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_frame_byte,
    input  logic                             s_frame_end,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_event_res,
    output logic [7:0]                       m_data_byte,
    output logic [7:0]                       m_type_byte,
    output logic [mfud_pkg::SEQ_W-1:0]       m_packet_seq,
    output logic [mfud_pkg::MSEQ_W-1:0]      m_msg_seq,
    output logic                             m_first_of_message,
    output logic                             m_last_of_message,
    output logic [mfud_pkg::MSEQ_W-1:0]      m_expected_seq
);

    typedef enum logic [2:0] {
        PH_SKIP, PH_HDR, PH_LEN, PH_TYPE, PH_PAY, PH_DONE
    } phase_t;

    logic [mfud_pkg::OFF_W-1:0]  header_offset_reg;
    logic [7:0]                  unit_id_reg;

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_end_reg;

    phase_t                      phase_reg, phase_next;
    logic [mfud_pkg::POS_W-1:0]  frame_pos_reg, frame_pos_next;
    logic [mfud_pkg::SEQ_W-1:0]  hdr_seq_reg, hdr_seq_next;
    logic [7:0]                  hdr_count_reg, hdr_count_next;
    logic [7:0]                  hdr_unit_reg, hdr_unit_next;
    logic [7:0]                  msgs_left_reg, msgs_left_next;
    logic [7:0]                  msg_len_reg, msg_len_next;
    logic [7:0]                  msg_byte_idx_reg, msg_byte_idx_next;
    logic [7:0]                  cur_type_reg, cur_type_next;
    logic [mfud_pkg::MSEQ_W-1:0] msg_seq_reg, msg_seq_next;
    logic [mfud_pkg::MSEQ_W-1:0] next_expected_reg, next_expected_next;
    logic                        dropping_reg, dropping_next;

    logic                        m_valid_reg;
    logic [1:0]                  m_event_reg;
    logic [7:0]                  m_data_reg;
    logic [7:0]                  m_type_reg;
    logic [mfud_pkg::SEQ_W-1:0]  m_pseq_reg;
    logic [mfud_pkg::MSEQ_W-1:0] m_mseq_reg;
    logic                        m_first_reg;
    logic                        m_last_reg;
    logic [mfud_pkg::MSEQ_W-1:0] m_exp_reg;

    logic                        res_valid;
    logic [1:0]                  res_event;
    logic [7:0]                  res_data;
    logic [7:0]                  res_type;
    logic [mfud_pkg::MSEQ_W-1:0] res_mseq;
    logic                        res_first;
    logic                        res_last;
    logic [mfud_pkg::MSEQ_W-1:0] res_exp;

    logic                        advance;
    logic                        msg_done;
    logic                        pay_last;
    logic [mfud_pkg::CMP_W-1:0]  pos_ext;
    logic [mfud_pkg::CMP_W-1:0]  off_ext;
    logic [mfud_pkg::CMP_W-1:0]  rel;

    assign advance = in_valid_reg && (!res_valid || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign pos_ext  = mfud_pkg::CMP_W'(frame_pos_reg);
    assign off_ext  = mfud_pkg::CMP_W'(header_offset_reg);
    assign rel      = pos_ext - off_ext;
    assign pay_last = ({1'b0, msg_byte_idx_reg} + mfud_pkg::LEN_OVERHEAD)
                      == {1'b0, msg_len_reg};

    always_comb begin
        phase_next         = phase_reg;
        frame_pos_next     = frame_pos_reg;
        hdr_seq_next       = hdr_seq_reg;
        hdr_count_next     = hdr_count_reg;
        hdr_unit_next      = hdr_unit_reg;
        msgs_left_next     = msgs_left_reg;
        msg_len_next       = msg_len_reg;
        msg_byte_idx_next  = msg_byte_idx_reg;
        cur_type_next      = cur_type_reg;
        msg_seq_next       = msg_seq_reg;
        next_expected_next = next_expected_reg;
        dropping_next      = dropping_reg;
        msg_done           = 1'b0;
        res_valid          = 1'b0;
        res_event          = mfud_pkg::EV_PAYLOAD;
        res_data           = '0;
        res_type           = '0;
        res_mseq           = '0;
        res_first          = 1'b0;
        res_last           = 1'b0;
        res_exp            = '0;

        if (!dropping_reg && phase_reg != PH_DONE) begin
            if (frame_pos_reg == mfud_pkg::POS_W'(mfud_pkg::MAX_FRAME_BYTES - 1)) begin
                dropping_next = 1'b1;
            end else begin
                frame_pos_next = frame_pos_reg + 1'b1;
            end

            case (phase_reg)
                PH_SKIP, PH_HDR: begin
                    if (pos_ext < off_ext) begin
                        phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_HDR;
                        if (rel >= mfud_pkg::CMP_W'(mfud_pkg::HDR_BYTES)) begin
                            dropping_next = 1'b1;
                        end else begin
                            case (rel[2:0])
                                mfud_pkg::HDR_COUNT_POS: hdr_count_next = in_byte_reg;
                                mfud_pkg::HDR_UNIT_POS:  hdr_unit_next  = in_byte_reg;
                                mfud_pkg::HDR_SEQ0_POS:  hdr_seq_next   = {24'd0, in_byte_reg};
                                mfud_pkg::HDR_SEQ1_POS:
                                    hdr_seq_next = hdr_seq_reg | {16'd0, in_byte_reg, 8'd0};
                                mfud_pkg::HDR_SEQ2_POS:
                                    hdr_seq_next = hdr_seq_reg | {8'd0, in_byte_reg, 16'd0};
                                mfud_pkg::HDR_SEQ3_POS:
                                    hdr_seq_next = hdr_seq_reg | {in_byte_reg, 24'd0};
                                default: ;
                            endcase
                            if (rel[2:0] == mfud_pkg::HDR_SEQ3_POS) begin
                                if (hdr_unit_next != unit_id_reg || hdr_seq_next == '0 ||
                                    hdr_count_next == '0) begin
                                    dropping_next = 1'b1;
                                end else begin
                                    if (next_expected_reg != '0 &&
                                        {1'b0, hdr_seq_next} != next_expected_reg &&
                                        hdr_seq_next != mfud_pkg::SEQ_W'(1)) begin
                                        res_valid = 1'b1;
                                        res_event = mfud_pkg::EV_GAP;
                                        res_exp   = next_expected_reg;
                                    end
                                    next_expected_next = {1'b0, hdr_seq_next}
                                                         + {25'd0, hdr_count_next};
                                    msgs_left_next     = hdr_count_next;
                                    msg_seq_next       = {1'b0, hdr_seq_next};
                                    phase_next         = PH_LEN;
                                end
                            end
                        end
                    end
                end
                PH_LEN: begin
                    if (in_byte_reg < mfud_pkg::MIN_MSG_LEN) begin
                        res_valid     = 1'b1;
                        res_event     = mfud_pkg::EV_BAD_LEN;
                        res_mseq      = msg_seq_reg;
                        dropping_next = 1'b1;
                    end else begin
                        msg_len_next = in_byte_reg;
                        phase_next   = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    cur_type_next = in_byte_reg;
                    if (msg_len_reg == mfud_pkg::MIN_MSG_LEN) begin
                        msg_done = 1'b1;
                    end else begin
                        msg_byte_idx_next = '0;
                        phase_next        = PH_PAY;
                    end
                end
                PH_PAY: begin
                    res_valid         = 1'b1;
                    res_event         = mfud_pkg::EV_PAYLOAD;
                    res_data          = in_byte_reg;
                    res_type          = cur_type_reg;
                    res_mseq          = msg_seq_reg;
                    res_first         = (msg_byte_idx_reg == '0);
                    res_last          = pay_last;
                    msg_byte_idx_next = msg_byte_idx_reg + 1'b1;
                    msg_done          = pay_last;
                end
                default: ;
            endcase

            if (msg_done) begin
                msgs_left_next = msgs_left_reg - 1'b1;
                if (msgs_left_reg == 8'd1) begin
                    phase_next = PH_DONE;
                end else begin
                    msg_seq_next = msg_seq_reg + 1'b1;
                    phase_next   = PH_LEN;
                end
            end
        end

        if (in_end_reg) begin
            frame_pos_next = '0;
            phase_next     = PH_SKIP;
            dropping_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_offset_reg <= mfud_pkg::OFFSET_RESET;
            unit_id_reg       <= mfud_pkg::UNIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                mfud_pkg::CFG_HEADER_OFFSET: header_offset_reg <= cfg_wr_data;
                mfud_pkg::CFG_UNIT_ID:       unit_id_reg <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_frame_byte;
            in_end_reg  <= s_frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_SKIP;
            frame_pos_reg     <= '0;
            hdr_seq_reg       <= '0;
            hdr_count_reg     <= '0;
            hdr_unit_reg      <= '0;
            msgs_left_reg     <= '0;
            msg_len_reg       <= '0;
            msg_byte_idx_reg  <= '0;
            cur_type_reg      <= '0;
            msg_seq_reg       <= '0;
            next_expected_reg <= '0;
            dropping_reg      <= 1'b0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            frame_pos_reg     <= frame_pos_next;
            hdr_seq_reg       <= hdr_seq_next;
            hdr_count_reg     <= hdr_count_next;
            hdr_unit_reg      <= hdr_unit_next;
            msgs_left_reg     <= msgs_left_next;
            msg_len_reg       <= msg_len_next;
            msg_byte_idx_reg  <= msg_byte_idx_next;
            cur_type_reg      <= cur_type_next;
            msg_seq_reg       <= msg_seq_next;
            next_expected_reg <= next_expected_next;
            dropping_reg      <= dropping_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && res_valid) begin
            m_event_reg <= res_event;
            m_data_reg  <= res_data;
            m_type_reg  <= res_type;
            m_pseq_reg  <= hdr_seq_next;
            m_mseq_reg  <= res_mseq;
            m_first_reg <= res_first;
            m_last_reg  <= res_last;
            m_exp_reg   <= res_exp;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_event_res        = m_event_reg;
    assign m_data_byte        = m_data_reg;
    assign m_type_byte        = m_type_reg;
    assign m_packet_seq       = m_pseq_reg;
    assign m_msg_seq          = m_mseq_reg;
    assign m_first_of_message = m_first_reg;
    assign m_last_of_message  = m_last_reg;
    assign m_expected_seq     = m_exp_reg;

    // payload phase always has a message outstanding
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAY |-> msgs_left_reg != '0)
        else $error("payload phase with no messages left");

    // gap transfer carries a nonzero expected sequence and no message sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == mfud_pkg::EV_GAP |-> m_expected_seq != '0 && m_msg_seq == '0)
        else $error("gap transfer with bad sequence fields");

    // only payload transfers carry data and message markers
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != mfud_pkg::EV_PAYLOAD |->
            !m_first_of_message && !m_last_of_message && m_data_byte == '0 && m_type_byte == '0)
        else $error("non-payload transfer with payload fields");

endmodule

// ----- bench/market_feed_unit_deframer_top_test.sv -----
// ----------------------------------------------------------------------------
// market_feed_unit_deframer_top_test: self-checking bench for the deframer
// Drives frame bytes through the input channel with random gaps and
// result back-pressure. A predictor of the skip, header and message logic
// builds the expected result events, and every result transfer is compared
// field by field with the oldest one waiting. A directed table opens the run.
// Random frames follow, with register changes between and inside frames,
// long receiver hold-offs and a stretch with no idling.
// ----------------------------------------------------------------------------
module market_feed_unit_deframer_top_test;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_MARK    = 1450;
    localparam int BUSY_MARK    = 1700;
    localparam int ITEM_TARGET  = 1950;

    typedef enum logic [2:0] {PH_SKIP, PH_HDR, PH_LEN, PH_TYPE, PH_PAY, PH_DONE} frame_phase_t;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [7:0]                  data;
        logic [7:0]                  mtype;
        logic [mfud_pkg::SEQ_W-1:0]  pseq;
        logic [mfud_pkg::MSEQ_W-1:0] mseq;
        logic                        msg_first;
        logic                        msg_last;
        logic [mfud_pkg::MSEQ_W-1:0] exp_seq;
    } feed_event_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        fend;
        logic [5:0]  reps;
        logic        typed;
        feed_event_t want;
    } stim_row_t;

    localparam feed_event_t NO_EV = '0;

    localparam stim_row_t DIR_TAB [0:25] = '{
        '{8'hFF, 1'b0, 6'd42, 1'b0, NO_EV},
        '{8'h00, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h02, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h01, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h02, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h00, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h03, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h00, 1'b0, 6'd1, 1'b1,
          '{mfud_pkg::EV_PAYLOAD, 8'h00, 8'hFF, 32'hFFFF_FFFF, 33'h1_0000_0000,
            1'b1, 1'b1, 33'd0}},
        '{8'h55, 1'b1, 6'd1, 1'b0, NO_EV},
        '{8'h00, 1'b0, 6'd42, 1'b0, NO_EV},
        '{8'h00, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h00, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h01, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h01, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h05, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h00, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h00, 1'b0, 6'd1, 1'b0, NO_EV},
        '{8'h00, 1'b0, 6'd1, 1'b1,
          '{mfud_pkg::EV_GAP, 8'h00, 8'h00, 32'd5, 33'd0, 1'b0, 1'b0, 33'h1_0000_0001}},
        '{8'h01, 1'b0, 6'd1, 1'b1,
          '{mfud_pkg::EV_BAD_LEN, 8'h00, 8'h00, 32'd5, 33'd5, 1'b0, 1'b0, 33'd0}},
        '{8'hAA, 1'b1, 6'd1, 1'b0, NO_EV}
    };

    logic                            aclk         = 1'b0;
    logic                            aresetn      = 1'b0;
    logic                            cfg_wr_en    = 1'b0;
    logic                            cfg_wr_index = 1'b0;
    logic [mfud_pkg::CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                            s_valid      = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_frame_byte = 8'd0;
    logic                            s_frame_end  = 1'b0;
    logic                            m_valid;
    logic                            m_ready      = 1'b0;
    logic [1:0]                      m_event_res;
    logic [7:0]                      m_data_byte;
    logic [7:0]                      m_type_byte;
    logic [mfud_pkg::SEQ_W-1:0]      m_packet_seq;
    logic [mfud_pkg::MSEQ_W-1:0]     m_msg_seq;
    logic                            m_first_of_message;
    logic                            m_last_of_message;
    logic [mfud_pkg::MSEQ_W-1:0]     m_expected_seq;

    // predictor state, at its reset values
    logic [mfud_pkg::OFF_W-1:0]  skip_len   = mfud_pkg::OFFSET_RESET;
    logic [7:0]                  unit_sel   = mfud_pkg::UNIT_RESET;
    logic [15:0]                 pos_q      = 16'd0;
    frame_phase_t                ph         = PH_SKIP;
    logic [mfud_pkg::SEQ_W-1:0]  hdr_seq    = '0;
    logic [7:0]                  hdr_count  = 8'd0;
    logic [7:0]                  hdr_unit   = 8'd0;
    logic [7:0]                  msgs_left  = 8'd0;
    logic [7:0]                  msg_len    = 8'd0;
    logic [7:0]                  msg_idx    = 8'd0;
    logic [7:0]                  cur_type   = 8'd0;
    logic [mfud_pkg::MSEQ_W-1:0] msg_seq    = '0;
    logic [mfud_pkg::MSEQ_W-1:0] next_seq   = '0;
    logic                        drop_frame = 1'b0;

    feed_event_t feed_q[$];
    logic [7:0]  frame_q[$];
    logic        idle_on   = 1'b1;
    int          hold_req  = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          sent      = 0;
    int          cycles    = 0;
    logic        fault     = 1'b0;

    market_feed_unit_deframer_top dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side back-pressure, long hold-offs counted here
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_seen + 1;
        end else begin
            m_ready <= !idle_on || ($urandom_range(99) >= 25);
        end
    end

    task automatic event_add(input feed_event_t e);
        feed_q.insert(feed_q.size(), e);
    endtask

    task automatic frame_add(input logic [7:0] v);
        frame_q.insert(frame_q.size(), v);
    endtask

    task automatic close_message();
        msgs_left = msgs_left - 8'd1;
        if (msgs_left == 8'd0) begin
            ph = PH_DONE;
        end else begin
            msg_seq = msg_seq + 33'd1;
            ph      = PH_LEN;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic fend);
        int          p;
        int          rel;
        feed_event_t ev;
        if (!drop_frame && ph != PH_DONE) begin
            p  = pos_q;
            ev = NO_EV;
            if (p + 1 >= mfud_pkg::MAX_FRAME_BYTES) drop_frame = 1'b1;
            else pos_q = 16'(p + 1);
            if (ph == PH_SKIP || ph == PH_HDR) begin
                if (p < int'(skip_len)) begin
                    ph = PH_SKIP;
                end else begin
                    rel = p - int'(skip_len);
                    ph  = PH_HDR;
                    if (rel >= mfud_pkg::HDR_BYTES) begin
                        drop_frame = 1'b1;
                    end else begin
                        if (rel == mfud_pkg::HDR_COUNT_POS) hdr_count = b;
                        else if (rel == mfud_pkg::HDR_UNIT_POS) hdr_unit = b;
                        else if (rel == mfud_pkg::HDR_SEQ0_POS) hdr_seq = {24'd0, b};
                        else if (rel > mfud_pkg::HDR_SEQ0_POS)
                            hdr_seq = hdr_seq | ({24'd0, b}
                                      << (8 * (rel - int'(mfud_pkg::HDR_SEQ0_POS))));
                        if (rel == mfud_pkg::HDR_SEQ3_POS) begin
                            if (hdr_unit != unit_sel || hdr_seq == '0 || hdr_count == 8'd0) begin
                                drop_frame = 1'b1;
                            end else begin
                                if (next_seq != '0 && {1'b0, hdr_seq} != next_seq
                                    && hdr_seq != 32'd1) begin
                                    ev.kind    = mfud_pkg::EV_GAP;
                                    ev.pseq    = hdr_seq;
                                    ev.exp_seq = next_seq;
                                    event_add(ev);
                                end
                                next_seq  = {1'b0, hdr_seq} + hdr_count;
                                msgs_left = hdr_count;
                                msg_seq   = {1'b0, hdr_seq};
                                ph        = PH_LEN;
                            end
                        end
                    end
                end
            end else if (ph == PH_LEN) begin
                if (b < mfud_pkg::MIN_MSG_LEN) begin
                    ev.kind = mfud_pkg::EV_BAD_LEN;
                    ev.pseq = hdr_seq;
                    ev.mseq = msg_seq;
                    event_add(ev);
                    drop_frame = 1'b1;
                end else begin
                    msg_len = b;
                    ph      = PH_TYPE;
                end
            end else if (ph == PH_TYPE) begin
                cur_type = b;
                if (msg_len == mfud_pkg::MIN_MSG_LEN) begin
                    close_message();
                end else begin
                    msg_idx = 8'd0;
                    ph      = PH_PAY;
                end
            end else begin
                ev.kind      = mfud_pkg::EV_PAYLOAD;
                ev.data      = b;
                ev.mtype     = cur_type;
                ev.pseq      = hdr_seq;
                ev.mseq      = msg_seq;
                ev.msg_first = (msg_idx == 8'd0);
                ev.msg_last  = ({1'b0, msg_idx} + mfud_pkg::LEN_OVERHEAD == {1'b0, msg_len});
                event_add(ev);
                msg_idx = msg_idx + 8'd1;
                if (ev.msg_last) close_message();
            end
        end
        if (fend) begin
            pos_q      = 16'd0;
            ph         = PH_SKIP;
            drop_frame = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [32:0] want,
                               input logic [32:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fault = 1'b1;
        end
    endtask

    always @(posedge aclk) begin : result_check
        feed_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (feed_q.size() == 0) begin
                $display("%0t: result with nothing awaited, expected none actual event %h",
                         $time, m_event_res);
                fault = 1'b1;
            end else begin
                want = feed_q.pop_front();
                check_field("event_res", want.kind, m_event_res);
                check_field("data_byte", want.data, m_data_byte);
                check_field("type_byte", want.mtype, m_type_byte);
                check_field("packet_seq", want.pseq, m_packet_seq);
                check_field("msg_seq", want.mseq, m_msg_seq);
                check_field("first_of_message", want.msg_first, m_first_of_message);
                check_field("last_of_message", want.msg_last, m_last_of_message);
                check_field("expected_seq", want.exp_seq, m_expected_seq);
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic fend, input logic typed,
                            input feed_event_t want);
        int held;
        held = feed_q.size();
        deframe_byte(b, fend);
        if (typed) begin
            while (feed_q.size() > held) void'(feed_q.pop_back());
            event_add(want);
        end
        if (idle_on) begin
            while ($urandom_range(99) < 25) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_frame_byte <= b;
        s_frame_end  <= fend;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_span(input int from, input int upto);
        for (int i = from; i < upto; i++)
            put_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, NO_EV);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (feed_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [mfud_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == mfud_pkg::CFG_HEADER_OFFSET) skip_len = val;
        else unit_sel = val[7:0];
    endtask

    task automatic build_frame();
        int          pick;
        int          n_msg;
        int          len;
        int          cut;
        logic [31:0] seq;
        frame_q.delete();
        repeat (skip_len) frame_add(8'($urandom));
        pick = $urandom_range(99);
        if (pick < 6) begin
            // line noise
            repeat ($urandom_range(1, 24)) frame_add(8'($urandom));
        end else begin
            n_msg = (pick < 9) ? 0 : (pick < 11) ? $urandom_range(100, 255)
                  : $urandom_range(1, 5);
            pick = $urandom_range(99);
            if (pick < 70 && next_seq != '0) seq = next_seq[31:0];
            else if (pick < 80) seq = next_seq[31:0] + $urandom_range(1, 9);
            else if (pick < 85) seq = 32'd1;
            else if (pick < 89) seq = 32'd0;
            else if (pick < 93) seq = 32'hFFFF_FFFF - $urandom_range(0, 3);
            else seq = $urandom;
            frame_add(8'($urandom));
            frame_add(8'($urandom));
            frame_add(8'(n_msg));
            frame_add(($urandom_range(99) < 5) ? unit_sel ^ 8'($urandom_range(1, 255))
                                               : unit_sel);
            for (int k = 0; k < 4; k++) frame_add(seq[8*k +: 8]);
            repeat (n_msg) begin
                pick = $urandom_range(99);
                len  = (pick < 3) ? $urandom_range(0, 1)
                     : (pick < 5) ? $urandom_range(13, 255)
                     : (n_msg > 5) ? $urandom_range(2, 3) : $urandom_range(2, 12);
                frame_add(8'(len));
                if (len >= 2) begin
                    frame_add(8'($urandom));
                    repeat (len - 2) frame_add(8'($urandom));
                end
            end
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(1, 4)) frame_add(8'($urandom));
        end
        if ($urandom_range(99) < 8) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
    endtask

    initial begin
        int          frames;
        int          cut;
        int          sel;
        logic [9:0]  off;
        logic [7:0]  u;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_TAB[r])
            repeat (DIR_TAB[r].reps)
                put_byte(DIR_TAB[r].b, DIR_TAB[r].fend, DIR_TAB[r].typed, DIR_TAB[r].want);

        frames = 0;
        while (sent < RAND_MARK) begin
            build_frame();
            if (frames % 8 == 7) begin
                // register change, often part-way through a frame
                cut = $urandom_range(0, frame_q.size() - 1);
                send_span(0, cut);
                settle();
                sel = $urandom_range(0, 4);
                off = (sel == 0) ? 10'd0 : (sel == 1) ? mfud_pkg::OFFSET_RESET
                    : (sel == 2) ? 10'd1 : 10'($urandom_range(2, 20));
                sel = $urandom_range(0, 4);
                u   = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF
                    : (sel == 2) ? mfud_pkg::UNIT_RESET : 8'($urandom);
                write_reg(mfud_pkg::CFG_HEADER_OFFSET, off);
                write_reg(mfud_pkg::CFG_UNIT_ID, {2'($urandom), u});
                send_span(cut, frame_q.size());
            end else begin
                send_span(0, frame_q.size());
            end
            if (frames == 2 || frames == 9) hold_req++;
            frames++;
        end

        // back to back with no idling
        settle();
        idle_on = 1'b0;
        while (sent < BUSY_MARK) begin
            build_frame();
            send_span(0, frame_q.size());
        end

        settle();
        idle_on = 1'b1;
        write_reg(mfud_pkg::CFG_HEADER_OFFSET, 10'd3);
        while (sent < ITEM_TARGET) begin
            build_frame();
            send_span(0, frame_q.size());
        end

        settle();
        repeat (12) @(posedge aclk);
        if (!fault) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
